// ===== design/arp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arp_pkg: shared types and constants of the ARP responder
// Field codes, status codes, register indexes, the scan token that walks the
// cell chain and the write command that the controller broadcasts.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam logic [15:0] HwEthernet = 16'h0001;
  localparam logic [15:0] ProtoIpv4  = 16'h0800;
  localparam logic [7:0]  MacBytes   = 8'd6;
  localparam logic [7:0]  Ipv4Bytes  = 8'd4;
  localparam logic [15:0] OpRequest  = 16'd1;

  localparam logic [2:0] StatOk         = 3'd0;
  localparam logic [2:0] StatBadHwType  = 3'd1;
  localparam logic [2:0] StatBadHwLen   = 3'd2;
  localparam logic [2:0] StatBadProto   = 3'd3;
  localparam logic [2:0] StatBadProtoLn = 3'd4;
  localparam logic [2:0] StatNotOurs    = 3'd5;

  localparam logic CfgOwnIp  = 1'b0;
  localparam logic CfgOwnMac = 1'b1;

  localparam logic [31:0] OwnIpReset  = 32'hB30A_025A;  // 179.10.2.90
  localparam logic [47:0] OwnMacReset = 48'hABAB_ABAB_ABAB;

  // Entry index width; covers tables of up to 256 entries.
  localparam int unsigned IdxW = 8;

  typedef enum logic [1:0] {
    StIdle,
    StLaunch,
    StScan,
    StFail
  } state_e;

  // Scan token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic            vld;
    logic            hit;
    logic            free;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] free_idx;
  } tok_t;

  // Append command, broadcast to all cells.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
  } wr_t;

endpackage
`default_nettype wire

// ===== design/arp_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cell: one translation table entry
// Holds valid, IP and MAC of one entry. Refreshes its MAC when the scan token
// finds the first match here, notes itself as the first free entry, and
// takes an append that is addressed to it.
// ----------------------------------------------------------------------------
module arp_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  arp_pkg::tok_t tok_i,
  output arp_pkg::tok_t tok_o,
  input  arp_pkg::wr_t  wr_i,
  input  logic [31:0]   sender_ip_i,
  input  logic [47:0]   sender_mac_i
);
  import arp_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic        valid_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  tok_t        tok_q, tok_d;
  logic        match, is_free, wr_sel;

  always_comb begin
    match   = tok_i.vld && !tok_i.hit && valid_q && (ip_q == sender_ip_i);
    is_free = tok_i.vld && !tok_i.free && !valid_q;
    wr_sel  = wr_i.en && (wr_i.idx == MyIdx);
    tok_d   = tok_i;
    if (match) begin
      tok_d.hit = 1'b1;
      tok_d.idx = MyIdx;
    end
    if (is_free) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  // Entry payload is read only where valid.
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      ip_q  <= sender_ip_i;
      mac_q <= sender_mac_i;
    end else if (match) begin
      mac_q <= sender_mac_i;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

// ===== design/arp_responder_with_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arp_responder_with_table: ARP message handler with IP-to-MAC table
// Validates one parsed ARP message, refreshes or appends a translation
// table entry and flags whether a reply is due.
// ----------------------------------------------------------------------------
// Usage: pulse start with the message fields while busy is low. The result
// appears on the result ports, marked by done_o for exactly one cycle; there
// is no backpressure, so the receiver must take it then. A message that
// passes validation keeps busy high through the launch and scan states: a
// scan token walks the row of table cells one cell per cycle, looking for
// the first entry whose IP matches the sender (its MAC is refreshed on the
// spot) and for the lowest free entry. When the token leaves the last cell
// the result is registered and, when the message is for us and the sender
// was unknown, the sender is appended to the free entry in that same cycle.
// A message that fails validation only passes the fail state and leaves the
// table untouched. The table is empty after reset; there is no clearing
// pass. The user must write own_ip / own_mac through the cfg port only while
// busy is low; the block does not enforce this. They are not read back.
// ----------------------------------------------------------------------------
module arp_responder_with_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [47:0] cfg_wdata_i,
  // item in
  input  logic        start,
  output logic        busy,
  input  logic [15:0] hw_type_i,
  input  logic [15:0] proto_type_i,
  input  logic [7:0]  hw_len_i,
  input  logic [7:0]  proto_len_i,
  input  logic [15:0] opcode_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] sender_ip_i,
  input  logic [31:0] target_ip_i,
  // result out
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        table_hit_o,
  output logic        entry_added_o,
  output logic        table_full_o,
  output logic [3:0]  entry_index_o,
  output logic        send_reply_o,
  output logic [47:0] reply_target_mac_o,
  output logic [31:0] reply_target_ip_o
);
  import arp_pkg::*;

  // Configuration registers
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= OwnIpReset;
      own_mac_q <= OwnMacReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgOwnIp:  own_ip_q  <= cfg_wdata_i[31:0];
        CfgOwnMac: own_mac_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // own_mac is only held here; no port drives it out of the block, so it is
  // folded into an unused signal.
  logic own_mac_unused;
  assign own_mac_unused = ^own_mac_q;

  // Control
  state_e state_q, state_d;
  logic   accept;
  logic   launch;
  logic   finish_ok;
  logic   finish_fail;

  // Latched item
  logic [15:0] opcode_q;
  logic [47:0] sender_mac_q;
  logic [31:0] sender_ip_q;
  logic        ours_q;
  logic [2:0]  chk_q;
  logic [2:0]  chk_code;

  // Cell chain
  tok_t tok_chain [TABLE_ENTRIES+1];
  wr_t  wr;

  assign accept = start && !busy;

  // Field checks, first failure wins.
  always_comb begin
    priority if (hw_type_i != HwEthernet) begin
      chk_code = StatBadHwType;
    end else if (hw_len_i != MacBytes) begin
      chk_code = StatBadHwLen;
    end else if (proto_type_i != ProtoIpv4) begin
      chk_code = StatBadProto;
    end else if (proto_len_i != Ipv4Bytes) begin
      chk_code = StatBadProtoLn;
    end else begin
      chk_code = StatOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q     <= opcode_i;
      sender_mac_q <= sender_mac_i;
      sender_ip_q  <= sender_ip_i;
      ours_q       <= (target_ip_i == own_ip_q);
      chk_q        <= chk_code;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = (chk_code == StatOk) ? StLaunch : StFail;
        end
      end
      StLaunch: state_d = StScan;
      StScan: begin
        if (tok_chain[TABLE_ENTRIES].vld) begin
          state_d = StIdle;
        end
      end
      StFail:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // State outputs
  always_comb begin
    busy        = 1'b1;
    launch      = 1'b0;
    finish_ok   = 1'b0;
    finish_fail = 1'b0;
    unique case (state_q)
      StIdle:   busy        = 1'b0;
      StLaunch: launch      = 1'b1;
      StScan:   finish_ok   = tok_chain[TABLE_ENTRIES].vld;
      StFail:   finish_fail = 1'b1;
      default:  busy        = 1'b1;
    endcase
  end

  // Token entering cell 0
  assign tok_chain[0] = '{vld: launch, default: '0};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    arp_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok_chain[g]),
      .tok_o       (tok_chain[g+1]),
      .wr_i        (wr),
      .sender_ip_i (sender_ip_q),
      .sender_mac_i(sender_mac_q)
    );
  end

  // Result from the token leaving the last cell
  tok_t            tok_end;
  logic            need_add;
  logic            do_add;
  logic            do_reply;
  logic [IdxW-1:0] sel_idx;

  always_comb begin
    tok_end  = tok_chain[TABLE_ENTRIES];
    need_add = ours_q && !tok_end.hit;
    do_add   = need_add && tok_end.free;
    do_reply = ours_q && (opcode_q == OpRequest);
    priority if (tok_end.hit) begin
      sel_idx = tok_end.idx;
    end else if (do_add) begin
      sel_idx = tok_end.free_idx;
    end else begin
      sel_idx = '0;
    end
    wr.en  = finish_ok && do_add;
    wr.idx = tok_end.free_idx;
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= finish_ok || finish_fail;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_ok) begin
      status_o           <= ours_q ? StatOk : StatNotOurs;
      table_hit_o        <= tok_end.hit;
      entry_added_o      <= do_add;
      table_full_o       <= need_add && !tok_end.free;
      entry_index_o      <= sel_idx[3:0];
      send_reply_o       <= do_reply;
      reply_target_mac_o <= do_reply ? sender_mac_q : 48'd0;
      reply_target_ip_o  <= do_reply ? sender_ip_q : 32'd0;
    end else if (finish_fail) begin
      status_o           <= chk_q;
      table_hit_o        <= 1'b0;
      entry_added_o      <= 1'b0;
      table_full_o       <= 1'b0;
      entry_index_o      <= 4'd0;
      send_reply_o       <= 1'b0;
      reply_target_mac_o <= 48'd0;
      reply_target_ip_o  <= 32'd0;
    end
  end

  assign done_o = done_q;

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("item finished without a result");

  a_hit_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(table_hit_o && entry_added_o))
    else $error("entry both refreshed and appended");

  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StatOk && status_o != StatNotOurs) |->
      (!send_reply_o && !table_hit_o && !entry_added_o))
    else $error("failed item touched the table or asked for a reply");

  a_tok_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_chain[TABLE_ENTRIES].vld |-> (state_q == StScan))
    else $error("scan token left the chain outside a scan");

endmodule
`default_nettype wire

// ===== sim/arp_responder_with_table_tb.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_table_tb: self-checking bench for the ARP responder
// Sends parsed ARP messages through the start/busy port and checks every
// done_o result against a typed verdict or a predictor that keeps its own
// copy of the table and of own_ip / own_mac. A short table of directed
// messages comes first, then random traffic over several register settings.
// ----------------------------------------------------------------------------
module arp_responder_with_table_tb;
  import arp_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned NDIR          = 19;
  localparam int unsigned NPHASES       = 5;
  localparam int unsigned PHASE_ITEMS   = 167;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam logic [15:0] OpReply       = 16'd2;

  // One parsed ARP message, as it goes into the block.
  typedef struct packed {
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arp_msg_t;

  // What the block reports for one message.
  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic        added;
    logic        full;
    logic [3:0]  index;
    logic        reply;
    logic [47:0] r_mac;
    logic [31:0] r_ip;
  } arp_verdict_t;

  // Directed row: message, whether the verdict is typed in, typed verdict.
  typedef struct packed {
    arp_msg_t     msg;
    logic         typed;
    arp_verdict_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [47:0] cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [15:0] hw_type_i;
  logic [15:0] proto_type_i;
  logic [7:0]  hw_len_i;
  logic [7:0]  proto_len_i;
  logic [15:0] opcode_i;
  logic [47:0] sender_mac_i;
  logic [31:0] sender_ip_i;
  logic [31:0] target_ip_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic        table_hit_o;
  logic        entry_added_o;
  logic        table_full_o;
  logic [3:0]  entry_index_o;
  logic        send_reply_o;
  logic [47:0] reply_target_mac_o;
  logic [31:0] reply_target_ip_o;

  arp_responder_with_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .busy              (busy),
    .hw_type_i         (hw_type_i),
    .proto_type_i      (proto_type_i),
    .hw_len_i          (hw_len_i),
    .proto_len_i       (proto_len_i),
    .opcode_i          (opcode_i),
    .sender_mac_i      (sender_mac_i),
    .sender_ip_i       (sender_ip_i),
    .target_ip_i       (target_ip_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .table_hit_o       (table_hit_o),
    .entry_added_o     (entry_added_o),
    .table_full_o      (table_full_o),
    .entry_index_o     (entry_index_o),
    .send_reply_o      (send_reply_o),
    .reply_target_mac_o(reply_target_mac_o),
    .reply_target_ip_o (reply_target_ip_o)
  );

  // Shadow of the translation table and the registers.
  logic        tbl_valid [TABLE_ENTRIES];
  logic [31:0] tbl_ip    [TABLE_ENTRIES];
  logic [47:0] tbl_mac   [TABLE_ENTRIES];
  logic [31:0] cur_ip;
  logic [47:0] cur_mac;

  arp_verdict_t pending_verdicts[$];
  dir_row_t     dir_tab [NDIR];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned n_sent, n_checked, n_hit, n_added, n_full, n_reply, n_rejected;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
               pending_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic arp_msg_t mk_msg(logic [15:0] hw, logic [15:0] proto,
                                      logic [7:0] hlen, logic [7:0] plen,
                                      logic [15:0] op, logic [47:0] smac,
                                      logic [31:0] sip, logic [31:0] tip);
    arp_msg_t m;
    m = '{hw, proto, hlen, plen, op, smac, sip, tip};
    return m;
  endfunction

  function automatic arp_verdict_t mk_res(logic [2:0] st, logic hit, logic add,
                                          logic full, logic [3:0] idx, logic rep,
                                          logic [47:0] rmac, logic [31:0] rip);
    arp_verdict_t v;
    v = '{st, hit, add, full, idx, rep, rmac, rip};
    return v;
  endfunction

  // Header checks in priority order, then lookup / refresh, then append and
  // reply when the message is for us. Updates the shadow table.
  function automatic arp_verdict_t predict_arp(arp_msg_t m);
    arp_verdict_t v;
    int           slot;
    v    = '0;
    slot = -1;
    if (m.hw_type != HwEthernet) begin
      v.status = StatBadHwType;
    end else if (m.hw_len != MacBytes) begin
      v.status = StatBadHwLen;
    end else if (m.proto_type != ProtoIpv4) begin
      v.status = StatBadProto;
    end else if (m.proto_len != Ipv4Bytes) begin
      v.status = StatBadProtoLn;
    end else begin
      v.status = StatOk;
      // first matching entry wins; refresh happens even if not for us
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!v.hit && tbl_valid[i] && tbl_ip[i] == m.sender_ip) begin
          tbl_mac[i] = m.sender_mac;
          v.hit      = 1'b1;
          v.index    = 4'(i);
        end
      end
      if (m.target_ip != cur_ip) begin
        v.status = StatNotOurs;
      end else begin
        if (!v.hit) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && !tbl_valid[i]) slot = i;
          end
          if (slot < 0) begin
            v.full = 1'b1;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_ip[slot]    = m.sender_ip;
            tbl_mac[slot]   = m.sender_mac;
            v.added         = 1'b1;
            v.index         = 4'(slot);
          end
        end
        if (m.opcode == OpRequest) begin
          v.reply = 1'b1;
          v.r_mac = m.sender_mac;
          v.r_ip  = m.sender_ip;
        end
      end
    end
    return v;
  endfunction

  // Mostly well-formed messages whose sender is often already in the table,
  // the rest header noise.
  function automatic arp_msg_t roll_msg();
    arp_msg_t    m;
    int unsigned sel, idx;
    m.opcode     = 16'($urandom);
    m.sender_mac = {16'($urandom), 32'($urandom)};
    if ($urandom_range(0, 9) < 7) begin
      m.hw_type    = HwEthernet;
      m.hw_len     = MacBytes;
      m.proto_type = ProtoIpv4;
      m.proto_len  = Ipv4Bytes;
      sel = $urandom_range(0, 3);
      if (sel < 2)       m.opcode = OpRequest;
      else if (sel == 2) m.opcode = OpReply;
    end else begin
      m.hw_type    = $urandom_range(0, 1) ? HwEthernet : 16'($urandom);
      m.hw_len     = $urandom_range(0, 1) ? MacBytes   : 8'($urandom);
      m.proto_type = $urandom_range(0, 1) ? ProtoIpv4  : 16'($urandom);
      m.proto_len  = $urandom_range(0, 1) ? Ipv4Bytes  : 8'($urandom);
    end
    sel = $urandom_range(0, 9);
    idx = $urandom_range(0, TABLE_ENTRIES - 1);
    if (sel < 5 && tbl_valid[idx]) m.sender_ip = tbl_ip[idx];
    else if (sel < 8)             m.sender_ip = 32'h0A00_0000 | $urandom_range(0, 23);
    else                          m.sender_ip = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 6)      m.target_ip = cur_ip;
    else if (sel < 8) m.target_ip = cur_ip ^ (32'd1 << $urandom_range(0, 31));
    else              m.target_ip = $urandom;
    return m;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Put one message on the port and hold it until it is taken. Returns at
  // the accepting edge with start still high.
  task automatic drive_msg(arp_msg_t m, logic typed, arp_verdict_t res);
    arp_verdict_t pred;
    hw_type_i    <= m.hw_type;
    proto_type_i <= m.proto_type;
    hw_len_i     <= m.hw_len;
    proto_len_i  <= m.proto_len;
    opcode_i     <= m.opcode;
    sender_mac_i <= m.sender_mac;
    sender_ip_i  <= m.sender_ip;
    target_ip_i  <= m.target_ip;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    pred = predict_arp(m);
    pending_verdicts.push_back(typed ? res : pred);
    n_sent++;
    n_hit      += pred.hit;
    n_added    += pred.added;
    n_full     += pred.full;
    n_reply    += pred.reply;
    n_rejected += (pred.status != StatOk && pred.status != StatNotOurs);
  endtask

  // Registers only change with the block drained and idle.
  task automatic write_cfg(logic [31:0] ip, logic [47:0] mac);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (TABLE_ENTRIES + 4) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgOwnIp;
    cfg_wdata_i <= {16'($urandom), ip};  // upper bits must be dropped
    @(posedge clk_i);
    cur_ip      = ip;
    cfg_addr_i  <= CfgOwnMac;
    cfg_wdata_i <= mac;
    @(posedge clk_i);
    cur_mac     = mac;
    cfg_we_i    <= 1'b0;
  endtask

  // Result checker: done_o has no backpressure, so every strobe is one item.
  always @(posedge clk_i) begin
    arp_verdict_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $display("[%0t] MISMATCH result with nothing outstanding", $time);
        err_cnt++;
      end else begin
        want = pending_verdicts.pop_front();
        n_checked++;
        if (status_o !== want.status)
          flag_mismatch("status", 64'(status_o), 64'(want.status));
        if (table_hit_o !== want.hit)
          flag_mismatch("table_hit", 64'(table_hit_o), 64'(want.hit));
        if (entry_added_o !== want.added)
          flag_mismatch("entry_added", 64'(entry_added_o), 64'(want.added));
        if (table_full_o !== want.full)
          flag_mismatch("table_full", 64'(table_full_o), 64'(want.full));
        if (entry_index_o !== want.index)
          flag_mismatch("entry_index", 64'(entry_index_o), 64'(want.index));
        if (send_reply_o !== want.reply)
          flag_mismatch("send_reply", 64'(send_reply_o), 64'(want.reply));
        if (reply_target_mac_o !== want.r_mac)
          flag_mismatch("reply_target_mac", 64'(reply_target_mac_o), 64'(want.r_mac));
        if (reply_target_ip_o !== want.r_ip)
          flag_mismatch("reply_target_ip", 64'(reply_target_ip_o), 64'(want.r_ip));
      end
    end
  end

  initial begin
    logic [31:0] own;
    logic [31:0] ip_a, ip_b, ip_c, ip_far;
    logic [47:0] mac0, mac1;
    own    = OwnIpReset;
    ip_a   = 32'h0A00_0001;
    ip_b   = 32'h0A00_0002;
    ip_c   = 32'h0A00_0003;
    ip_far = 32'hC0A8_0101;
    mac0   = 48'h0200_0000_0001;
    mac1   = 48'h0200_0000_0002;

    err_cnt    = 0;
    cycle_cnt  = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_hit      = 0;
    n_added    = 0;
    n_full     = 0;
    n_reply    = 0;
    n_rejected = 0;
    cur_ip     = OwnIpReset;
    cur_mac    = OwnMacReset;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i]    = '0;
      tbl_mac[i]   = '0;
    end

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = CfgOwnIp;
    cfg_wdata_i  = '0;
    start        = 1'b0;
    hw_type_i    = '0;
    proto_type_i = '0;
    hw_len_i     = '0;
    proto_len_i  = '0;
    opcode_i     = '0;
    sender_mac_i = '0;
    sender_ip_i  = '0;
    target_ip_i  = '0;

    // Directed rows. Header rejects, the first two appends, a refresh and the
    // not-for-us cases are typed in; the rest is predicted.
    dir_tab[0]  = '{mk_msg(16'h0000, ProtoIpv4, MacBytes, Ipv4Bytes, OpRequest,
                           '0, '0, own), 1'b1,
                    mk_res(StatBadHwType, 0, 0, 0, 0, 0, '0, '0)};
    // every header field wrong: hardware type is reported first
    dir_tab[1]  = '{mk_msg(16'hFFFF, 16'h0000, 8'h00, 8'h00, 16'hFFFF,
                           '1, '1, '1), 1'b1,
                    mk_res(StatBadHwType, 0, 0, 0, 0, 0, '0, '0)};
    // bad length beats bad protocol
    dir_tab[2]  = '{mk_msg(HwEthernet, 16'hFFFF, 8'h00, Ipv4Bytes, OpRequest,
                           mac0, ip_a, own), 1'b1,
                    mk_res(StatBadHwLen, 0, 0, 0, 0, 0, '0, '0)};
    dir_tab[3]  = '{mk_msg(HwEthernet, ProtoIpv4, 8'hFF, Ipv4Bytes, OpRequest,
                           mac0, ip_a, own), 1'b1,
                    mk_res(StatBadHwLen, 0, 0, 0, 0, 0, '0, '0)};
    dir_tab[4]  = '{mk_msg(HwEthernet, 16'h0000, MacBytes, 8'h00, OpRequest,
                           mac0, ip_a, own), 1'b1,
                    mk_res(StatBadProto, 0, 0, 0, 0, 0, '0, '0)};
    dir_tab[5]  = '{mk_msg(HwEthernet, 16'hFFFF, MacBytes, Ipv4Bytes, OpRequest,
                           mac0, ip_a, own), 1'b1,
                    mk_res(StatBadProto, 0, 0, 0, 0, 0, '0, '0)};
    dir_tab[6]  = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, 8'h00, OpRequest,
                           mac0, ip_a, own), 1'b1,
                    mk_res(StatBadProtoLn, 0, 0, 0, 0, 0, '0, '0)};
    dir_tab[7]  = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, 8'hFF, OpRequest,
                           mac0, ip_a, own), 1'b1,
                    mk_res(StatBadProtoLn, 0, 0, 0, 0, 0, '0, '0)};
    // first good request after reset lands in entry 0 and gets a reply
    dir_tab[8]  = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpRequest,
                           mac0, ip_a, own), 1'b1,
                    mk_res(StatOk, 0, 1, 0, 0, 1, mac0, ip_a)};
    // same sender, new MAC: refresh of entry 0
    dir_tab[9]  = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpRequest,
                           mac1, ip_a, own), 1'b1,
                    mk_res(StatOk, 1, 0, 0, 0, 1, mac1, ip_a)};
    // not for us, known sender: still refreshed
    dir_tab[10] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpReply,
                           mac0, ip_a, ip_far), 1'b1,
                    mk_res(StatNotOurs, 1, 0, 0, 0, 0, '0, '0)};
    // not for us, unknown sender: nothing happens
    dir_tab[11] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpRequest,
                           mac0, ip_b, ip_far), 1'b1,
                    mk_res(StatNotOurs, 0, 0, 0, 0, 0, '0, '0)};
    // reply opcode for us: appended, no reply
    dir_tab[12] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpReply,
                           mac1, ip_b, own), 1'b1,
                    mk_res(StatOk, 0, 1, 0, 1, 0, '0, '0)};
    dir_tab[13] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, 16'h0000,
                           mac0, ip_c, own), 1'b0, '0};
    dir_tab[14] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, 16'hFFFF,
                           mac1, ip_c, own), 1'b0, '0};
    dir_tab[15] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpRequest,
                           '1, 32'h0000_0000, own), 1'b0, '0};
    dir_tab[16] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpRequest,
                           '0, 32'hFFFF_FFFF, own), 1'b0, '0};
    // near misses on the target compare
    dir_tab[17] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpRequest,
                           mac0, ip_a, own ^ 32'h0000_0001), 1'b0, '0};
    dir_tab[18] = '{mk_msg(HwEthernet, ProtoIpv4, MacBytes, Ipv4Bytes, OpRequest,
                           mac1, 32'h0A00_0004, own ^ 32'h8000_0000), 1'b0, '0};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NDIR; r++) begin
      drive_msg(dir_tab[r].msg, dir_tab[r].typed, dir_tab[r].res);
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end

    // Random traffic, one register setting per phase; the table fills up in
    // the first phase and stays full after that (no way to drop entries).
    for (int ph = 0; ph < NPHASES; ph++) begin
      case (ph)
        1: write_cfg(32'h0000_0000, 48'h0000_0000_0000);
        2: write_cfg(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        3: write_cfg($urandom, {16'($urandom), 32'($urandom)});
        4: write_cfg(OwnIpReset, {16'($urandom), 32'($urandom)});
        default: ;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off once until the block has drained
        if (ph == 1 && k == 60) begin
          start <= 1'b0;
          while (pending_verdicts.size() != 0) @(posedge clk_i);
        end
        drive_msg(roll_msg(), 1'b0, '0);
        // last phase runs back to back
        if (ph < NPHASES - 1 && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk_i);
        end
      end
    end
    start <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (TABLE_ENTRIES + 8) @(posedge clk_i);

    $display("%0d messages sent, %0d results checked over %0d register settings",
             n_sent, n_checked, NPHASES);
    $display("%0d refreshes, %0d appends, %0d full-table, %0d replies, %0d rejects",
             n_hit, n_added, n_full, n_reply, n_rejected);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/arp_pkg.sv
design/arp_cell.sv
design/arp_responder_with_table.sv
sim/arp_responder_with_table_tb.sv
